[rtl/sv39ptw_pkg.sv]
// shared types and constants of the sv39 page table walker
`timescale 1ns / 1ps
`default_nettype none

package sv39ptw_pkg;

  localparam int unsigned TableWordsDef  = 4096;
  localparam int unsigned VaLimitBitsDef = 38;

  localparam int unsigned PPN_W   = 44;
  localparam int unsigned VA_W    = 39;
  localparam int unsigned PA_W    = 56;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned VPN_W   = 9;
  localparam int unsigned OFF_W   = 12;
  localparam int unsigned FAULT_W = 3;
  localparam int unsigned PAGE_ENTRIES = 512;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 120;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 4;

  // pte bit positions
  localparam int unsigned PTE_V   = 0;
  localparam int unsigned PTE_R   = 1;
  localparam int unsigned PTE_W   = 2;
  localparam int unsigned PTE_PPN = 10;

  localparam logic CMD_WRITE     = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  localparam logic REG_ROOT = 1'b0;
  localparam logic REG_BASE = 1'b1;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE    = 3'd0,
    FAULT_LIMIT   = 3'd1,
    FAULT_INVALID = 3'd2,
    FAULT_NO_RW   = 3'd3,
    FAULT_WINDOW  = 3'd4
  } fault_e;

  typedef struct packed {
    logic [PPN_W-1:0] root_page;
    logic [PPN_W-1:0] base_page;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/sv39_page_table_walker_top.sv]
// top level of the sv39 page table walker
//
//  channel  | dir | handshake          | contents
//  ---------+-----+--------------------+----------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tuser command, tdata index, value, address
//  m_*      | out | m_tvalid/m_tready  | tdata page address, physical address, fault
//  apb      | in  | psel/penable       | root table page (0x0), window base page (0x8)
//
// a write item goes to the table memory as it is accepted; a translate item that succeeds
// needs three dependent table reads, each with registered read data; a fault on the
// address limit or the root window check returns without a table read.
// while the result register is still full, the last step of a walk waits.
// reset clears the configuration, control and result registers; table memory and its read data are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sv39_page_table_walker_top #(
  parameter int unsigned TABLE_WORDS   = sv39ptw_pkg::TableWordsDef,
  parameter int unsigned VA_LIMIT_BITS = sv39ptw_pkg::VaLimitBitsDef
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // [11:0] word_index, [75:12] word_value, [114:76] virtual_address
  input  wire logic [sv39ptw_pkg::IN_DATA_W-1:0]     s_tdata,
  // [0] command
  input  wire logic                                  s_tuser,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // [55:0] page_address, [111:56] physical_address, [114:112] fault_code
  output logic      [sv39ptw_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [sv39ptw_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [sv39ptw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [sv39ptw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                       pready
);

  localparam int unsigned AW = $clog2(TABLE_WORDS);

  sv39ptw_pkg::cfg_t                  cfg;
  logic                               mem_we;
  logic [AW-1:0]                      mem_waddr;
  logic [sv39ptw_pkg::WORD_W-1:0]     mem_wdata;
  logic                               mem_re;
  logic [AW-1:0]                      mem_raddr;
  logic [sv39ptw_pkg::WORD_W-1:0]     mem_rdata;
  logic [sv39ptw_pkg::PA_W-1:0]       page_address;
  logic [sv39ptw_pkg::PA_W-1:0]       physical_address;
  sv39ptw_pkg::fault_e                fault_code;

  sv39ptw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sv39ptw_mem #(
    .DEPTH (TABLE_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sv39ptw_walk #(
    .TABLE_WORDS   (TABLE_WORDS),
    .VA_LIMIT_BITS (VA_LIMIT_BITS),
    .AW            (AW)
  ) u_walk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (s_tvalid),
    .in_ready_o         (s_tready),
    .command_i          (s_tuser),
    .word_index_i       (s_tdata[11:0]),
    .word_value_i       (s_tdata[75:12]),
    .virtual_address_i  (s_tdata[114:76]),
    .out_valid_o        (m_tvalid),
    .out_ready_i        (m_tready),
    .page_address_o     (page_address),
    .physical_address_o (physical_address),
    .fault_code_o       (fault_code),
    .mem_we_o           (mem_we),
    .mem_waddr_o        (mem_waddr),
    .mem_wdata_o        (mem_wdata),
    .mem_re_o           (mem_re),
    .mem_raddr_o        (mem_raddr),
    .mem_rdata_i        (mem_rdata)
  );

  sv39ptw_top_pack u_pack (
    .page_address_i     (page_address),
    .physical_address_i (physical_address),
    .fault_code_i       (fault_code),
    .tdata_o            (m_tdata)
  );

endmodule

`default_nettype wire

[rtl/sv39ptw_mem.sv]
// table memory: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module sv39ptw_mem #(
  parameter int unsigned DEPTH = sv39ptw_pkg::TableWordsDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [AW-1:0]                  waddr_i,
  input  wire logic [sv39ptw_pkg::WORD_W-1:0] wdata_i,
  input  wire logic                           re_i,
  input  wire logic [AW-1:0]                  raddr_i,
  output logic      [sv39ptw_pkg::WORD_W-1:0] rdata_o
);

  logic [sv39ptw_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [sv39ptw_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/sv39ptw_cfg.sv]
// configuration registers behind the apb port
`timescale 1ns / 1ps
`default_nettype none

module sv39ptw_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sv39ptw_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [sv39ptw_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [sv39ptw_pkg::APB_DATA_W-1:0] prdata,
  output logic                                    pready,
  output sv39ptw_pkg::cfg_t                       cfg_o
);

  sv39ptw_pkg::cfg_t cfg_q, cfg_d;
  logic              wr_en;
  logic              sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  // registers sit at 8-byte steps
  assign sel    = paddr[3];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        sv39ptw_pkg::REG_ROOT: cfg_d.root_page = pwdata[sv39ptw_pkg::PPN_W-1:0];
        sv39ptw_pkg::REG_BASE: cfg_d.base_page = pwdata[sv39ptw_pkg::PPN_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (sel)
      sv39ptw_pkg::REG_ROOT: prdata = sv39ptw_pkg::APB_DATA_W'(cfg_q.root_page);
      sv39ptw_pkg::REG_BASE: prdata = sv39ptw_pkg::APB_DATA_W'(cfg_q.base_page);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/sv39ptw_walk.sv]
// walk sequencer: takes items, drives the table memory, holds the result register
`timescale 1ns / 1ps
`default_nettype none

module sv39ptw_walk #(
  parameter int unsigned TABLE_WORDS   = sv39ptw_pkg::TableWordsDef,
  parameter int unsigned VA_LIMIT_BITS = sv39ptw_pkg::VaLimitBitsDef,
  parameter int unsigned AW            = $clog2(TABLE_WORDS)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire sv39ptw_pkg::cfg_t               cfg_i,
  // input item
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            command_i,
  input  wire logic [sv39ptw_pkg::IDX_W-1:0]   word_index_i,
  input  wire logic [sv39ptw_pkg::WORD_W-1:0]  word_value_i,
  input  wire logic [sv39ptw_pkg::VA_W-1:0]    virtual_address_i,
  // result item
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [sv39ptw_pkg::PA_W-1:0]    page_address_o,
  output logic      [sv39ptw_pkg::PA_W-1:0]    physical_address_o,
  output sv39ptw_pkg::fault_e                  fault_code_o,
  // table memory
  output logic                                 mem_we_o,
  output logic      [AW-1:0]                   mem_waddr_o,
  output logic      [sv39ptw_pkg::WORD_W-1:0]  mem_wdata_o,
  output logic                                 mem_re_o,
  output logic      [AW-1:0]                   mem_raddr_o,
  input  wire logic [sv39ptw_pkg::WORD_W-1:0]  mem_rdata_i
);

  localparam int unsigned PPN_W = sv39ptw_pkg::PPN_W;
  localparam int unsigned VPN_W = sv39ptw_pkg::VPN_W;
  localparam int unsigned FULL_W = PPN_W + VPN_W;
  localparam logic [PPN_W-1:0] WinPages = PPN_W'(TABLE_WORDS / sv39ptw_pkg::PAGE_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_e;

  state_e                           state_q, state_d;
  logic [1:0]                       level_q, level_d;
  logic [sv39ptw_pkg::VA_W-1:0]     va_q, va_d;
  sv39ptw_pkg::fault_e              fault_q, fault_d;
  logic                             out_valid_q, out_valid_d;
  logic [sv39ptw_pkg::PA_W-1:0]     page_q, page_d;
  logic [sv39ptw_pkg::PA_W-1:0]     phys_q, phys_d;
  sv39ptw_pkg::fault_e              out_fault_q, out_fault_d;

  logic                             in_fire;
  logic                             out_free;
  logic [PPN_W-1:0]                 entry_ppn;
  logic [PPN_W-1:0]                 page_sel;
  logic [VPN_W-1:0]                 idx_sel;
  logic [PPN_W-1:0]                 rel;
  logic                             in_win;
  logic [FULL_W-1:0]                full_addr;
  logic                             over_limit;
  logic [AW+sv39ptw_pkg::IDX_W-1:0] wr_ext;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign entry_ppn  = mem_rdata_i[sv39ptw_pkg::PTE_PPN +: PPN_W];

  // one window check shared by the root lookup and the lower levels
  always_comb begin
    if (state_q == ST_IDLE) begin
      page_sel = cfg_i.root_page;
      idx_sel  = virtual_address_i[38:30];
    end else begin
      page_sel = entry_ppn;
      idx_sel  = (level_q == 2'd2) ? va_q[29:21] : va_q[20:12];
    end
  end

  assign rel         = page_sel - cfg_i.base_page;
  assign in_win      = (page_sel >= cfg_i.base_page) && (rel < WinPages);
  assign full_addr   = {rel, idx_sel};
  assign mem_raddr_o = full_addr[AW-1:0];

  assign over_limit = (virtual_address_i >> VA_LIMIT_BITS) != '0;

  assign wr_ext      = {{AW{1'b0}}, word_index_i};
  assign mem_waddr_o = wr_ext[AW-1:0];
  assign mem_wdata_o = word_value_i;

  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    va_d        = va_q;
    fault_d     = fault_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    page_d      = page_q;
    phys_d      = phys_q;
    out_fault_d = out_fault_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (command_i == sv39ptw_pkg::CMD_WRITE) begin
            mem_we_o = (32'(word_index_i) < TABLE_WORDS);
          end else begin
            va_d = virtual_address_i;
            if (over_limit) begin
              fault_d = sv39ptw_pkg::FAULT_LIMIT;
              state_d = ST_EMIT;
            end else if (!in_win) begin
              fault_d = sv39ptw_pkg::FAULT_WINDOW;
              state_d = ST_EMIT;
            end else begin
              mem_re_o = 1'b1;
              level_d  = 2'd2;
              state_d  = ST_WALK;
            end
          end
        end
      end

      ST_WALK: begin
        if (mem_rdata_i[sv39ptw_pkg::PTE_V] && level_q != 2'd0 && in_win) begin
          // pointer to the next table
          mem_re_o = 1'b1;
          level_d  = level_q - 2'd1;
        end else if (out_free) begin
          // walk ends here; otherwise hold, read data stays put
          out_valid_d = 1'b1;
          page_d      = '0;
          phys_d      = '0;
          state_d     = ST_IDLE;
          if (!mem_rdata_i[sv39ptw_pkg::PTE_V]) begin
            out_fault_d = sv39ptw_pkg::FAULT_INVALID;
          end else if (level_q != 2'd0) begin
            out_fault_d = sv39ptw_pkg::FAULT_WINDOW;
          end else if (!mem_rdata_i[sv39ptw_pkg::PTE_R] &&
                       !mem_rdata_i[sv39ptw_pkg::PTE_W]) begin
            out_fault_d = sv39ptw_pkg::FAULT_NO_RW;
          end else begin
            out_fault_d = sv39ptw_pkg::FAULT_NONE;
            page_d      = {entry_ppn, {sv39ptw_pkg::OFF_W{1'b0}}};
            phys_d      = {entry_ppn, va_q[sv39ptw_pkg::OFF_W-1:0]};
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          page_d      = '0;
          phys_d      = '0;
          out_fault_d = fault_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      level_q     <= 2'd0;
      va_q        <= '0;
      fault_q     <= sv39ptw_pkg::FAULT_NONE;
      out_valid_q <= 1'b0;
      page_q      <= '0;
      phys_q      <= '0;
      out_fault_q <= sv39ptw_pkg::FAULT_NONE;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      va_q        <= va_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
      page_q      <= page_d;
      phys_q      <= phys_d;
      out_fault_q <= out_fault_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign page_address_o     = page_q;
  assign physical_address_o = phys_q;
  assign fault_code_o       = out_fault_q;

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("table write and read in the same cycle");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fault_code_o != sv39ptw_pkg::FAULT_NONE) |->
      (page_address_o == '0 && physical_address_o == '0))
    else $error("faulted result carries an address");

  a_write_no_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && command_i == sv39ptw_pkg::CMD_WRITE) |=> state_q == ST_IDLE)
    else $error("write item started a walk");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> level_q != 2'd3)
    else $error("walk level out of range");

  a_offset_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> page_address_o[sv39ptw_pkg::OFF_W-1:0] == '0)
    else $error("page address not page aligned");

endmodule

`default_nettype wire

[rtl/sv39ptw_top.sv]
// packing of the result fields into the master-side tdata
`timescale 1ns / 1ps
`default_nettype none

module sv39ptw_top_pack (
  input  wire logic [sv39ptw_pkg::PA_W-1:0]    page_address_i,
  input  wire logic [sv39ptw_pkg::PA_W-1:0]    physical_address_i,
  input  wire sv39ptw_pkg::fault_e             fault_code_i,
  output logic      [sv39ptw_pkg::OUT_DATA_W-1:0] tdata_o
);

  // result fields packed from the lowest bit up, padded to whole bytes
  assign tdata_o = {5'b0, fault_code_i, physical_address_i, page_address_i};

endmodule

`default_nettype wire
